// ----- hdl/qsl_pkg.sv -----
// ----------------------------------------------------------------------------
// qsl_pkg : shared types and constants for the quaternion slerp unit
// Fixed-point formats, CORDIC angle table and result status codes.
// ----------------------------------------------------------------------------
package qsl_pkg;

  localparam int FRAC_BITS_DEF    = 14;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int Q_W      = 16;            // quaternion component, Q1.14
  localparam int BLEND_W  = 17;            // blend factor, Q1.16
  localparam int OUT_FRAC = 14;
  localparam int DOT_W    = 30;            // clamped dot, Q28 signed
  localparam int PW       = 58;            // (1-d)(1+d) in Q56
  localparam int M2W      = 64;            // sum of squares of the blend
  localparam int NW       = 31;            // blend in Q26, signed
  localparam int QB       = OUT_FRAC + 1;  // quotient bits of the normaliser
  localparam int VXW      = 32;            // vectoring CORDIC x / y
  localparam int TW       = 34;            // theta, Q32 radians
  localparam int AW       = 35;            // scaled angle, Q32 radians
  localparam int ZW       = 37;            // CORDIC angle accumulator

  localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(65536);

  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q32      = (PI_Q60 + (64'd1 << 27)) >> 28;
  localparam logic [63:0] HALF_PI_Q32 = (PI_Q60 + (64'd1 << 28)) >> 29;
  localparam logic [63:0] INVK_Q32    = 64'h9B74EDA8;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_START  = 2'd1,
    ST_DEGEN  = 2'd2
  } status_t;

  // atan(2^-i) in Q32 radians, rounded to nearest
  function automatic logic [63:0] atan_q32(input int i);
    logic [63:0] v;
    case (i)
      0:       v = 64'd3373259426;
      1:       v = 64'd1991351318;
      2:       v = 64'd1052175346;
      3:       v = 64'd534100635;
      4:       v = 64'd268086748;
      5:       v = 64'd134174063;
      6:       v = 64'd67103403;
      7:       v = 64'd33553749;
      8:       v = 64'd16777131;
      9:       v = 64'd8388597;
      10:      v = 64'd4194303;
      default: v = 64'd1 << (32 - i);
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/qsl_delay.sv -----
// ----------------------------------------------------------------------------
// qsl_delay : enabled shift line
// Carries side data alongside the cell chains, DEPTH levels deep.
// ----------------------------------------------------------------------------
module qsl_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1,
  parameter bit CLR   = 1'b0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         ce,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst && CLR) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else if (ce) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ----- hdl/qsl_isqrt_cell.sv -----
// ----------------------------------------------------------------------------
// qsl_isqrt_cell : one root bit of a digit-by-digit integer square root
// Subtract the trial value when it fits, then hand remainder and root on.
// ----------------------------------------------------------------------------
module qsl_isqrt_cell
  import qsl_pkg::*;
#(
  parameter int W   = 58,
  parameter int POS = 0
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] n_in,
  input  logic [W-1:0] r_in,
  output logic [W-1:0] n_out,
  output logic [W-1:0] r_out
);

  localparam logic [W-1:0] B = W'(1) << (2 * POS);

  logic [W-1:0] trial;
  assign trial = r_in + B;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (n_in >= trial) begin
        n_out <= n_in - trial;
        r_out <= (r_in >> 1) + B;
      end else begin
        n_out <= n_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

// ----- hdl/qsl_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// qsl_cordic_cell : one CORDIC micro-rotation
// Vectoring drives y towards zero; rotation drives z towards zero.
// ----------------------------------------------------------------------------
module qsl_cordic_cell
  import qsl_pkg::*;
#(
  parameter int XW        = 32,
  parameter int STEP      = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  localparam logic signed [ZW-1:0] ANGLE = ZW'(atan_q32(STEP));

  logic signed [XW-1:0] dx, dy;
  logic                 turn_pos;

  assign dx       = y_in >>> STEP;
  assign dy       = x_in >>> STEP;
  assign turn_pos = VECTORING ? !(y_in > 0) : (z_in >= 0);

  always_ff @(posedge clk) begin
    if (ce) begin
      if (turn_pos) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ANGLE;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ANGLE;
      end
    end
  end

endmodule

// ----- hdl/qsl_div_cell.sv -----
// ----------------------------------------------------------------------------
// qsl_div_cell : one quotient bit of a restoring divider
// Take the shifted divisor off the remainder when it fits and set the bit.
// ----------------------------------------------------------------------------
module qsl_div_cell
  import qsl_pkg::*;
#(
  parameter int DW  = 47,
  parameter int VW  = 32,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [DW-1:0] rem_in,
  input  logic [VW-1:0] div_in,
  input  logic [QB-1:0] q_in,
  output logic [DW-1:0] rem_out,
  output logic [VW-1:0] div_out,
  output logic [QB-1:0] q_out
);

  logic [DW-1:0] trial;
  assign trial = DW'(div_in) << BIT;

  always_ff @(posedge clk) begin
    if (ce) begin
      div_out <= div_in;
      if (rem_in >= trial) begin
        rem_out <= rem_in - trial;
        q_out   <= q_in | (QB'(1) << BIT);
      end else begin
        rem_out <= rem_in;
        q_out   <= q_in;
      end
    end
  end

endmodule

// ----- hdl/quaternion_slerp_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_slerp_unit : pipelined spherical linear interpolation
// Blends two Q1.14 quaternions by t and normalises the interpolated result.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields (lowest bit first)
// s_       in   tdata: from_x from_y from_z from_w to_x to_y to_z to_w blend
// m_       out  tdata: out_x out_y out_z out_w ; tuser: status
//
// One transfer is taken every cycle while m_ is not stalled. The chain of cells
// holds two 1-bit-per-cycle square roots (29 and 32 cells), the vectoring and
// the rotating CORDIC rows and four 15-cell restoring dividers.
// The whole row advances on one enable, so a result held at m_ with
// m_tready low holds every stage and s_tready falls in the same cycle.
// Reset (rst, synchronous) drops all items in flight; no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_slerp_unit
  import qsl_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,   // from_x..from_w, to_x..to_w, blend, zero fill
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // out_x, out_y, out_z, out_w
  output logic [1:0]   m_tuser    // status
);

  localparam int F     = FRAC_BITS;
  localparam int STEPS = CORDIC_STEPS;
  localparam int XW    = F + 3;          // sine CORDIC x / y
  localparam int BCW   = F + 20;         // blend in Q(14+F)
  localparam int K1    = PW / 2;
  localparam int K2    = M2W / 2;
  localparam int DW    = NW + OUT_FRAC + 2;

  // pipeline levels
  localparam int LR = 3 + K1;            // root of (1-d)(1+d)
  localparam int LV = LR + STEPS;        // vectoring done
  localparam int LT = LV + 1;            // theta
  localparam int LA = LT + 1;            // scaled angles
  localparam int LS = LA + STEPS;        // sines
  localparam int LB = LS + 1;            // blend
  localparam int LN = LB + 1;            // blend in Q26
  localparam int LM = LN + 2;            // sum of squares
  localparam int LG = LM + K2;           // magnitude
  localparam int LD = LG + 1;            // divider set-up
  localparam int LQ = LD + QB;           // quotients

  localparam int NSR = (F >= 12) ? F - 12 : 0;
  localparam int NSL = (F >= 12) ? 0 : 12 - F;
  localparam longint NHALF = (NSR == 0) ? 0 : (longint'(1) << (NSR - 1));
  localparam longint FHALF = longint'(1) << (F - 1);
  localparam logic [63:0] INVK_F = (INVK_Q32 + (64'd1 << (31 - F))) >> (32 - F);

  localparam logic signed [33:0] ONE34  = 34'sd268435456;
  localparam logic signed [30:0] ONE31  = 31'sd268435456;
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI_Q32);
  localparam logic signed [ZW-1:0] HPI_Z  = ZW'(HALF_PI_Q32);

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // ---- level 1: products of the dot, blend saturation ----------------------
  logic signed [Q_W-1:0] in_from [4];
  logic signed [Q_W-1:0] in_to   [4];
  logic [BLEND_W-1:0]    in_blend;
  logic signed [31:0]    prod1 [4];
  logic [63:0]           from1, to1;
  logic [BLEND_W-1:0]    t1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_from[k] = s_tdata[16*k +: 16];
      in_to[k]   = s_tdata[64 + 16*k +: 16];
    end
  end
  assign in_blend = s_tdata[128 +: BLEND_W];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) prod1[k] <= 32'(in_from[k]) * 32'(in_to[k]);
      from1 <= s_tdata[63:0];
      to1   <= s_tdata[127:64];
      t1    <= (in_blend > BLEND_ONE) ? BLEND_ONE : in_blend;
    end
  end

  // ---- level 2: clamp the dot to [-1, 1] -----------------------------------
  logic signed [33:0]      dsum;
  logic signed [DOT_W-1:0] d2;
  logic                    eq1_2, eqm1_2;

  assign dsum = 34'(prod1[0]) + 34'(prod1[1]) + 34'(prod1[2]) + 34'(prod1[3]);

  always_ff @(posedge clk) begin
    if (ce) begin
      if (dsum > ONE34)       d2 <= DOT_W'(ONE34);
      else if (dsum < -ONE34) d2 <= DOT_W'(-ONE34);
      else                    d2 <= DOT_W'(dsum);
      eq1_2  <= (dsum >= ONE34);
      eqm1_2 <= (dsum <= -ONE34);
    end
  end

  // ---- level 3: (1-d)(1+d) -------------------------------------------------
  logic signed [30:0] pa_s, pb_s;
  logic [59:0]        pprod;
  logic [PW-1:0]      p3;

  assign pa_s  = ONE31 - 31'(d2);
  assign pb_s  = ONE31 + 31'(d2);
  assign pprod = 60'(pa_s[29:0]) * 60'(pb_s[29:0]);

  always_ff @(posedge clk) begin
    if (ce) p3 <= pprod[PW-1:0];
  end

  // ---- sqrt(1-d^2), one root bit per cell ----------------------------------
  logic [PW-1:0] sq1_n [K1+1];
  logic [PW-1:0] sq1_r [K1+1];
  assign sq1_n[0] = p3;
  assign sq1_r[0] = '0;

  for (genvar j = 0; j < K1; j++) begin : g_sq1
    qsl_isqrt_cell #(.W(PW), .POS(K1 - 1 - j)) u_sq (
      .clk(clk), .ce(ce),
      .n_in(sq1_n[j]), .r_in(sq1_r[j]),
      .n_out(sq1_n[j+1]), .r_out(sq1_r[j+1])
    );
  end

  logic signed [DOT_W-1:0] d_lr;
  qsl_delay #(.W(DOT_W), .DEPTH(LR - 2)) u_dly_d (
    .clk(clk), .rst(rst), .ce(ce), .d(d2), .q(d_lr)
  );

  // ---- acos by vectoring CORDIC; a negative dot is turned by -pi/2 first ---
  logic signed [VXW-1:0] vx [STEPS+1];
  logic signed [VXW-1:0] vy [STEPS+1];
  logic signed [ZW-1:0]  vz [STEPS+1];
  logic signed [VXW-1:0] root_x;

  assign root_x = $signed(VXW'(sq1_r[K1][K1-1:0]));
  assign vx[0]  = (d_lr < 0) ? root_x : VXW'(d_lr);
  assign vy[0]  = (d_lr < 0) ? -VXW'(d_lr) : root_x;
  assign vz[0]  = (d_lr < 0) ? HPI_Z : '0;

  for (genvar j = 0; j < STEPS; j++) begin : g_vec
    qsl_cordic_cell #(.XW(VXW), .STEP(j), .VECTORING(1'b1)) u_vec (
      .clk(clk), .ce(ce),
      .x_in(vx[j]), .y_in(vy[j]), .z_in(vz[j]),
      .x_out(vx[j+1]), .y_out(vy[j+1]), .z_out(vz[j+1])
    );
  end

  // ---- theta clamped to [0, pi] --------------------------------------------
  logic [TW-1:0] theta;
  always_ff @(posedge clk) begin
    if (ce) begin
      if (vz[STEPS] < 0)         theta <= '0;
      else if (vz[STEPS] > PI_Z) theta <= TW'(PI_Z);
      else                       theta <= TW'(vz[STEPS]);
    end
  end

  logic [BLEND_W-1:0] t_th;
  qsl_delay #(.W(BLEND_W), .DEPTH(LT - 1)) u_dly_t (
    .clk(clk), .rst(rst), .ce(ce), .d(t1), .q(t_th)
  );

  // ---- (1-t) theta and t theta, rounded to Q32 -----------------------------
  logic [50:0]   ma, mb;
  logic [AW-1:0] ang_a, ang_b;

  assign ma = 51'(BLEND_ONE - t_th) * 51'(theta) + 51'd32768;
  assign mb = 51'(t_th) * 51'(theta) + 51'd32768;

  always_ff @(posedge clk) begin
    if (ce) begin
      ang_a <= AW'(ma >> 16);
      ang_b <= AW'(mb >> 16);
    end
  end

  // ---- two rotating CORDIC rows for the sine weights -----------------------
  logic signed [XW-1:0] sax [STEPS+1];
  logic signed [XW-1:0] say [STEPS+1];
  logic signed [ZW-1:0] saz [STEPS+1];
  logic signed [XW-1:0] sbx [STEPS+1];
  logic signed [XW-1:0] sby [STEPS+1];
  logic signed [ZW-1:0] sbz [STEPS+1];

  // fold angles above pi/2 back into the first quadrant
  assign sax[0] = XW'(INVK_F);
  assign say[0] = '0;
  assign saz[0] = (ang_a > AW'(HALF_PI_Q32)) ? PI_Z - ZW'(ang_a) : ZW'(ang_a);
  assign sbx[0] = XW'(INVK_F);
  assign sby[0] = '0;
  assign sbz[0] = (ang_b > AW'(HALF_PI_Q32)) ? PI_Z - ZW'(ang_b) : ZW'(ang_b);

  for (genvar j = 0; j < STEPS; j++) begin : g_sin
    qsl_cordic_cell #(.XW(XW), .STEP(j), .VECTORING(1'b0)) u_sa (
      .clk(clk), .ce(ce),
      .x_in(sax[j]), .y_in(say[j]), .z_in(saz[j]),
      .x_out(sax[j+1]), .y_out(say[j+1]), .z_out(saz[j+1])
    );
    qsl_cordic_cell #(.XW(XW), .STEP(j), .VECTORING(1'b0)) u_sb (
      .clk(clk), .ce(ce),
      .x_in(sbx[j]), .y_in(sby[j]), .z_in(sbz[j]),
      .x_out(sbx[j+1]), .y_out(sby[j+1]), .z_out(sbz[j+1])
    );
  end

  logic [63:0] from_ls, to_ls;
  qsl_delay #(.W(128), .DEPTH(LS - 1)) u_dly_q (
    .clk(clk), .rst(rst), .ce(ce), .d({to1, from1}), .q({to_ls, from_ls})
  );

  // ---- blend: start*wa + end*wb --------------------------------------------
  logic signed [BCW-1:0] bc [4];
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        bc[k] <= BCW'($signed(from_ls[16*k +: 16])) * BCW'(say[STEPS])
               + BCW'($signed(to_ls[16*k +: 16])) * BCW'(sby[STEPS]);
      end
    end
  end

  // ---- bring the blend to Q26 ----------------------------------------------
  logic signed [BCW+11:0] nwide [4];
  logic signed [NW-1:0]   n5 [4];

  always_comb begin
    for (int k = 0; k < 4; k++)
      nwide[k] = (((BCW+12)'(bc[k]) + (BCW+12)'(NHALF)) >>> NSR) <<< NSL;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) n5[k] <= NW'(nwide[k]);
    end
  end

  // ---- squares, then their sum ---------------------------------------------
  logic signed [2*NW-1:0] sq6 [4];
  logic [M2W-1:0]         m2;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) sq6[k] <= (2*NW)'(n5[k]) * (2*NW)'(n5[k]);
      m2 <= M2W'(sq6[0]) + M2W'(sq6[1]) + M2W'(sq6[2]) + M2W'(sq6[3]);
    end
  end

  // ---- magnitude, one root bit per cell ------------------------------------
  logic [M2W-1:0] sq2_n [K2+1];
  logic [M2W-1:0] sq2_r [K2+1];
  assign sq2_n[0] = m2;
  assign sq2_r[0] = '0;

  for (genvar j = 0; j < K2; j++) begin : g_sq2
    qsl_isqrt_cell #(.W(M2W), .POS(K2 - 1 - j)) u_sq (
      .clk(clk), .ce(ce),
      .n_in(sq2_n[j]), .r_in(sq2_r[j]),
      .n_out(sq2_n[j+1]), .r_out(sq2_r[j+1])
    );
  end

  logic [K2-1:0] mag;
  assign mag = sq2_r[K2][K2-1:0];

  logic [4*NW-1:0] n_lg;
  qsl_delay #(.W(4*NW), .DEPTH(LG - LN)) u_dly_n (
    .clk(clk), .rst(rst), .ce(ce),
    .d({n5[3], n5[2], n5[1], n5[0]}), .q(n_lg)
  );

  // ---- divider set-up: |n| * 2^14 + mag/2 ----------------------------------
  logic [DW-1:0] rem0 [4];
  logic [K2-1:0] div0;
  logic [3:0]    neg_ld;
  logic          zero_ld;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 4; k++) begin
        if (n_lg[NW*k + NW - 1])
          rem0[k] <= (DW'(-$signed(n_lg[NW*k +: NW])) << OUT_FRAC) + DW'(mag >> 1);
        else
          rem0[k] <= (DW'(n_lg[NW*k +: NW]) << OUT_FRAC) + DW'(mag >> 1);
        neg_ld[k] <= n_lg[NW*k + NW - 1];
      end
      div0    <= mag;
      zero_ld <= (mag == '0);
    end
  end

  // ---- four restoring dividers, one quotient bit per cell ------------------
  logic [DW-1:0] dr  [4][QB+1];
  logic [K2-1:0] dv  [4][QB+1];
  logic [QB-1:0] dq  [4][QB+1];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign dr[k][0] = rem0[k];
    assign dv[k][0] = div0;
    assign dq[k][0] = '0;
    for (genvar j = 0; j < QB; j++) begin : g_div
      qsl_div_cell #(.DW(DW), .VW(K2), .BIT(QB - 1 - j)) u_div (
        .clk(clk), .ce(ce),
        .rem_in(dr[k][j]), .div_in(dv[k][j]), .q_in(dq[k][j]),
        .rem_out(dr[k][j+1]), .div_out(dv[k][j+1]), .q_out(dq[k][j+1])
      );
    end
  end

  logic [3:0] neg_lq;
  logic       zero_lq;
  qsl_delay #(.W(5), .DEPTH(QB)) u_dly_sgn (
    .clk(clk), .rst(rst), .ce(ce), .d({zero_ld, neg_ld}), .q({zero_lq, neg_lq})
  );

  logic [63:0] from_lq;
  qsl_delay #(.W(64), .DEPTH(LQ - LS)) u_dly_from (
    .clk(clk), .rst(rst), .ce(ce), .d(from_ls), .q(from_lq)
  );

  logic [4*BCW-1:0] bc_lq;
  qsl_delay #(.W(4*BCW), .DEPTH(LQ - LB)) u_dly_bc (
    .clk(clk), .rst(rst), .ce(ce),
    .d({bc[3], bc[2], bc[1], bc[0]}), .q(bc_lq)
  );

  logic eq1_lq, eqm1_lq;
  qsl_delay #(.W(2), .DEPTH(LQ - 2)) u_dly_flag (
    .clk(clk), .rst(rst), .ce(ce), .d({eqm1_2, eq1_2}), .q({eqm1_lq, eq1_lq})
  );

  logic valid_lq;
  qsl_delay #(.W(1), .DEPTH(LQ), .CLR(1'b1)) u_dly_vld (
    .clk(clk), .rst(rst), .ce(ce), .d(s_tvalid), .q(valid_lq)
  );

  // ---- result select and output register -----------------------------------
  logic signed [BCW:0] deg_w [4];
  logic [15:0]         res   [4];
  status_t             st;

  always_comb begin
    for (int k = 0; k < 4; k++)
      deg_w[k] = ((BCW+1)'($signed(bc_lq[BCW*k +: BCW])) + (BCW+1)'(FHALF)) >>> F;
    if (eq1_lq) begin
      st = ST_START;
      for (int k = 0; k < 4; k++) res[k] = from_lq[16*k +: 16];
    end else if (eqm1_lq || zero_lq) begin
      // unnormalised blend, saturated to 16 bits
      st = ST_DEGEN;
      for (int k = 0; k < 4; k++) begin
        if (deg_w[k] > 32767)       res[k] = 16'h7FFF;
        else if (deg_w[k] < -32768) res[k] = 16'h8000;
        else                        res[k] = 16'(deg_w[k]);
      end
    end else begin
      st = ST_INTERP;
      for (int k = 0; k < 4; k++)
        res[k] = neg_lq[k] ? -16'(dq[k][QB]) : 16'(dq[k][QB]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= valid_lq;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {res[3], res[2], res[1], res[0]};
      m_tuser <= st;
    end
  end

endmodule
